@@ src/bh_pkg.sv @@
// bh_pkg: shared types and constants for the byte histogram
// no dependencies

package bh_pkg;

  // count width of one bin and number of bins
  localparam int CNT_W     = 16;
  localparam int NUM_BINS  = 256;
  localparam int IDX_W     = $clog2(NUM_BINS);
  localparam int OUT_CNT_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // command codes; the unused code behaves as a read
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // item held in the update stage
  typedef struct packed {
    logic             vld;
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx;
  } item_t;

  // bin memory write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } wr_t;

  // result of the update stage
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             sat;
    logic [IDX_W-1:0] best_byte;
    logic [CNT_W-1:0] best_count;
  } upd_t;

endpackage

@@ src/bh_bin_mem.sv @@
// bh_bin_mem: bin count storage, one write and one registered read per cycle
// depends on bh_pkg

module bh_bin_mem
  import bh_pkg::*;
(
  input  logic             clk,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] mem [NUM_BINS];
  logic [CNT_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/bh_tracker.sv @@
// bh_tracker: per-bin valid marks, count update with forwarding, running mode
// depends on bh_pkg

module bh_tracker
  import bh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  item_t            item,
  input  logic [CNT_W-1:0] rd_data,
  output wr_t              wr,
  output upd_t             upd
);

  logic [NUM_BINS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]    best_byte_r, best_byte_nxt;
  logic [CNT_W-1:0]    best_count_r, best_count_nxt;
  logic                fwd_vld_r, fwd_vld_nxt;
  logic [IDX_W-1:0]    fwd_idx_r;
  logic [CNT_W-1:0]    fwd_cnt_r;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic                fwd_hit;

  // current bin value: 0 if unset, memory word, or word written last cycle
  assign fwd_hit = fwd_vld_r && (fwd_idx_r == item.idx);

  always_comb begin
    if (!valid_r[item.idx]) begin
      cur_cnt = '0;
    end else if (fwd_hit) begin
      cur_cnt = fwd_cnt_r;
    end else begin
      cur_cnt = rd_data;
    end
  end

  // saturating increment
  assign new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

  // command decode
  always_comb begin
    valid_nxt      = valid_r;
    best_byte_nxt  = best_byte_r;
    best_count_nxt = best_count_r;
    fwd_vld_nxt    = 1'b0;
    wr.en          = 1'b0;
    wr.addr        = item.idx;
    wr.data        = new_cnt;
    upd.cnt        = cur_cnt;
    upd.sat        = (cur_cnt == CNT_MAX);
    if (item.vld) begin
      case (item.cmd)
        CMD_CLEAR: begin
          valid_nxt      = '0;
          best_byte_nxt  = '0;
          best_count_nxt = '0;
          upd.cnt        = '0;
          upd.sat        = 1'b0;
        end
        CMD_COUNT: begin
          valid_nxt[item.idx] = 1'b1;
          wr.en               = 1'b1;
          fwd_vld_nxt         = 1'b1;
          upd.cnt             = new_cnt;
          upd.sat             = (new_cnt == CNT_MAX);
          if ((new_cnt > best_count_r) ||
              ((new_cnt == best_count_r) && (item.idx >= best_byte_r))) begin
            best_byte_nxt  = item.idx;
            best_count_nxt = new_cnt;
          end
        end
        default: begin
          // read, nothing changes
        end
      endcase
    end
    upd.best_byte  = best_byte_nxt;
    upd.best_count = best_count_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      best_byte_r  <= '0;
      best_count_r <= '0;
      fwd_vld_r    <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      best_byte_r  <= best_byte_nxt;
      best_count_r <= best_count_nxt;
      fwd_vld_r    <= fwd_vld_nxt;
    end
  end

  // forwarded word
  always_ff @(posedge clk) begin
    fwd_idx_r <= item.idx;
    fwd_cnt_r <= new_cnt;
  end

endmodule

@@ src/byte_histogram_with_mode.sv @@
// byte_histogram_with_mode: top level of the 256-bin byte histogram
// depends on bh_pkg, bh_bin_mem, bh_tracker
//
// Usage:
//   Input channel: a word (in_command, in_byte_value) is taken at a rising
//   edge where start is high and busy is low. busy stays low, so one word
//   can be taken every clock cycle.
//   Commands: clear empties all bins and the mode, count adds one to the
//   bin of the byte (saturating), read returns the bin's count; the unused
//   code reads as well.
//   Result channel: out_valid is high for exactly one cycle per word, with
//   the bin count, the mode byte and count, and the saturation flag.
//   Result path: the result passes two register stages, first the input
//   and bin memory read registers, then the result registers.
//   Throughput: one word per cycle; back-to-back counts of the same byte
//   are handled by forwarding the word written in the previous cycle.
//   Reset (synchronous, rst_n low): all bins read as empty, the mode is
//   cleared and no result is pending. The receiver cannot stall, so every
//   result must be taken in its cycle.

module byte_histogram_with_mode
  import bh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_byte_value,
  output logic                 out_valid,
  output logic [OUT_CNT_W-1:0] out_bin_count,
  output logic [7:0]           out_mode_byte,
  output logic [OUT_CNT_W-1:0] out_mode_count,
  output logic                 out_saturated
);

  item_t            item_r, item_nxt;
  wr_t              wr;
  upd_t             upd;
  logic [CNT_W-1:0] rd_data;
  logic             out_valid_r;
  logic [OUT_CNT_W-1:0] out_bin_count_r;
  logic [7:0]       out_mode_byte_r;
  logic [OUT_CNT_W-1:0] out_mode_count_r;
  logic             out_saturated_r;

  assign busy = 1'b0;

  // input stage
  always_comb begin
    item_nxt.vld = start && !busy;
    item_nxt.cmd = in_command;
    item_nxt.idx = in_byte_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= item_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    item_r.cmd <= item_nxt.cmd;
    item_r.idx <= item_nxt.idx;
  end

  // bin storage, read issued as the word is taken
  bh_bin_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (in_byte_value),
    .rd_data (rd_data)
  );

  // update stage
  bh_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item_r),
    .rd_data (rd_data),
    .wr      (wr),
    .upd     (upd)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_bin_count_r  <= OUT_CNT_W'(upd.cnt);
    out_mode_byte_r  <= upd.best_byte;
    out_mode_count_r <= OUT_CNT_W'(upd.best_count);
    out_saturated_r  <= upd.sat;
  end

  assign out_valid      = out_valid_r;
  assign out_bin_count  = out_bin_count_r;
  assign out_mode_byte  = out_mode_byte_r;
  assign out_mode_count = out_mode_count_r;
  assign out_saturated  = out_saturated_r;

endmodule

@@ tb/sv/tb_byte_histogram_with_mode.sv @@
// tb_byte_histogram_with_mode: self-checking testbench for the 256-bin byte histogram
// depends on bh_pkg and byte_histogram_with_mode; drives words, predicts and checks every result

module tb_byte_histogram_with_mode;
  import bh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // the command code that has no enum member; the block treats it as a read
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 8;

  // one result word as seen on the output ports
  typedef struct packed {
    logic [OUT_CNT_W-1:0] bin_count;
    logic [7:0]           mode_byte;
    logic [OUT_CNT_W-1:0] mode_count;
    logic                 saturated;
  } hist_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_command = CMD_READ;
  logic [7:0]           in_byte_value = 8'd0;
  logic                 out_valid;
  logic [OUT_CNT_W-1:0] out_bin_count;
  logic [7:0]           out_mode_byte;
  logic [OUT_CNT_W-1:0] out_mode_count;
  logic                 out_saturated;

  // predicted histogram state
  logic [CNT_W-1:0] hist_count [NUM_BINS];
  logic             hist_valid [NUM_BINS];
  logic [7:0]       mode_byte_q;
  logic [CNT_W-1:0] mode_count_q;

  hist_word_t  expected_words[$];
  int unsigned mismatch_count = 0;

  byte_histogram_with_mode u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_bin_count  (out_bin_count),
    .out_mode_byte  (out_mode_byte),
    .out_mode_count (out_mode_count),
    .out_saturated  (out_saturated)
  );

  always #2 clk = ~clk;

  // apply one accepted word to the predicted histogram and return its result
  function automatic hist_word_t histogram_step(input logic [1:0] cmd, input logic [7:0] b);
    hist_word_t       w;
    logic [CNT_W-1:0] c;
    w = '0;
    c = hist_valid[b] ? hist_count[b] : '0;
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_BINS; i++) hist_valid[i] = 1'b0;
        mode_byte_q  = 8'd0;
        mode_count_q = '0;
        c = '0;
      end
      CMD_COUNT: begin
        if (c != CNT_MAX) c = c + 1'b1;
        hist_count[b] = c;
        hist_valid[b] = 1'b1;
        // ties go to the larger byte code
        if (c > mode_count_q || (c == mode_count_q && b >= mode_byte_q)) begin
          mode_count_q = c;
          mode_byte_q  = b;
        end
      end
      default: begin
      end
    endcase
    w.bin_count  = OUT_CNT_W'(c);
    w.mode_byte  = mode_byte_q;
    w.mode_count = OUT_CNT_W'(mode_count_q);
    w.saturated  = (cmd != CMD_CLEAR) && (c == CNT_MAX);
    return w;
  endfunction

  // drive one word, wait for the handshake, then drop start and idle for the gap if it is nonzero
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] b, input int unsigned gap);
    start         <= 1'b1;
    in_command    <= cmd;
    in_byte_value <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(histogram_step(cmd, b));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every expected result has come back
  task automatic drain_words();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned any_gap();
    return $urandom_range(0, 18);
  endfunction

  // empty histogram after reset: every read is zero, including the spare code
  task automatic test_reset_state();
    send_word(CMD_READ, 8'h00, any_gap());
    send_word(CMD_READ, 8'hFF, 0);
    send_word(CMD_SPARE, 8'h5A, any_gap());
    send_word(CMD_SPARE, 8'hA5, 0);
  endtask

  // field extremes, every command, tie-breaking and clear
  task automatic test_directed();
    send_word(CMD_COUNT, 8'h00, 0);
    send_word(CMD_COUNT, 8'hFF, any_gap());
    send_word(CMD_COUNT, 8'h00, 0);
    send_word(CMD_COUNT, 8'hFF, 0);
    send_word(CMD_READ, 8'h00, any_gap());
    send_word(CMD_READ, 8'hFF, 0);
    send_word(CMD_SPARE, 8'hFF, 0);
    send_word(CMD_COUNT, 8'hA5, any_gap());
    send_word(CMD_COUNT, 8'h5A, 0);
    send_word(CMD_CLEAR, 8'hFF, 0);
    send_word(CMD_READ, 8'hFF, any_gap());
    send_word(CMD_READ, 8'h00, 0);
    send_word(CMD_COUNT, 8'h01, 0);
    // smaller code ties the mode and must not take it
    send_word(CMD_COUNT, 8'h00, any_gap());
    send_word(CMD_CLEAR, 8'h00, 0);
    send_word(CMD_CLEAR, 8'h00, 0);
    send_word(CMD_SPARE, 8'h01, any_gap());
  endtask

  // random words, mostly counts over a few hot bytes so that ties and runs build up
  task automatic test_random(input int unsigned n_words);
    logic [7:0]  hot_bytes [4];
    logic [1:0]  cmd;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned gap;
    bit          burst;
    burst = 1'b0;
    for (int i = 0; i < 4; i++) hot_bytes[i] = 8'($urandom_range(0, 255));
    for (int unsigned n = 0; n < n_words; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n % 200 == 199) drain_words();
      pick = $urandom_range(0, 99);
      if (pick < 60) cmd = CMD_COUNT;
      else if (pick < 85) cmd = CMD_READ;
      else if (pick < 95) cmd = CMD_SPARE;
      else cmd = CMD_CLEAR;
      if ($urandom_range(0, 9) < 7) b = hot_bytes[$urandom_range(0, 3)];
      else b = 8'($urandom_range(0, 255));
      if (cmd == CMD_CLEAR)
        for (int i = 0; i < 4; i++) hot_bytes[i] = 8'($urandom_range(0, 255));
      gap = burst ? 0 : any_gap();
      send_word(cmd, b, gap);
    end
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    hist_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_bin_count !== exp_w.bin_count) begin
          $error("bin_count: expected %0d, actual %0d", exp_w.bin_count, out_bin_count);
          mismatch_count++;
        end
        if (out_mode_byte !== exp_w.mode_byte) begin
          $error("mode_byte: expected %0d, actual %0d", exp_w.mode_byte, out_mode_byte);
          mismatch_count++;
        end
        if (out_mode_count !== exp_w.mode_count) begin
          $error("mode_count: expected %0d, actual %0d", exp_w.mode_count, out_mode_count);
          mismatch_count++;
        end
        if (out_saturated !== exp_w.saturated) begin
          $error("saturated: expected %0d, actual %0d", exp_w.saturated, out_saturated);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < NUM_BINS; i++) begin
      hist_count[i] = '0;
      hist_valid[i] = 1'b0;
    end
    mode_byte_q  = 8'd0;
    mode_count_q = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random(800);
    drain_words();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_byte_histogram_with_mode: PASS");
    end else begin
      $display("tb_byte_histogram_with_mode: FAIL");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #(5_000_000);
    $display("tb_byte_histogram_with_mode: FAIL");
    $finish;
  end

endmodule
